FILE: rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the sparse polynomial adder: payload
// structs, command codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned EXPON_W = 16;
  localparam int unsigned SUM_W   = 33;

  // input command codes; the fourth code is ignored
  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_MERGE         = 2'd2
  } spa_op_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COEF_W-1:0]  term_coef;
    logic [EXPON_W-1:0]        term_expon;
  } spa_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   out_coef;
    logic [EXPON_W-1:0]        out_expon;
    logic                      term_valid;
    logic                      last_term;
    logic                      overflow;
  } spa_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_FLUSH
  } spa_state_e;

  // controller to datapath
  typedef struct packed {
    logic append_first;
    logic append_second;
    logic merge_start;
    logic fetch;
    logic step;
    logic flush;
  } spa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic produce;
    logic pend_valid;
    logic out_free;
  } spa_stat_t;

endpackage

`default_nettype wire

FILE: rtl/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl
// Sequencer for the sparse polynomial adder: takes appends and the merge
// command, then steps the merge loop (fetch, compare) and the final flush.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ctrl
  import spa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic [1:0] in_cmd_i,
  output logic           in_ready_o,
  input  wire spa_stat_t stat_i,
  output spa_cmd_t       cmd_o
);

  spa_state_e state_q, state_d;
  logic       stall;

  // a new term cannot replace the pending one while the output is blocked
  assign stall = stat_i.produce && stat_i.pend_valid && !stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_cmd_i == OP_MERGE)) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (stat_i.done) begin
          state_d = ST_FLUSH;
        end else if (!stall) begin
          state_d = ST_FETCH;
        end
      end
      ST_FLUSH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        unique case (in_cmd_i)
          OP_APPEND_FIRST:  cmd_o.append_first  = in_valid_i;
          OP_APPEND_SECOND: cmd_o.append_second = in_valid_i;
          OP_MERGE:         cmd_o.merge_start   = in_valid_i;
          default: ;
        endcase
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      ST_CMP: begin
        cmd_o.step = !stat_i.done && !stall;
      end
      ST_FLUSH: begin
        cmd_o.flush = stat_i.out_free;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_flush_ends_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush |=> (state_q == ST_IDLE))
    else $error("flush did not return the controller to idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/spa_dpath.sv
// ----------------------------------------------------------------------------
// spa_dpath
// Datapath of the sparse polynomial adder: two term memories with fill
// counts, merge pointers, exponent compare and coefficient add, a one-term
// hold-back register that lets the final term carry the last mark, and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_dpath
  import spa_pkg::*;
#(
  parameter int unsigned TERMS_PER_LIST = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire spa_in_t  in_data_i,
  input  wire spa_cmd_t cmd_i,
  output spa_stat_t     stat_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output spa_out_t      out_data_o
);

  localparam int unsigned CW = $clog2(TERMS_PER_LIST + 1);
  localparam int unsigned AW = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
  localparam logic [CW-1:0] DEPTH = CW'(TERMS_PER_LIST);

  // term memories
  logic signed [COEF_W-1:0] first_coefs   [TERMS_PER_LIST];
  logic [EXPON_W-1:0]       first_expons  [TERMS_PER_LIST];
  logic signed [COEF_W-1:0] second_coefs  [TERMS_PER_LIST];
  logic [EXPON_W-1:0]       second_expons [TERMS_PER_LIST];

  logic [CW-1:0] cnt_a_q, cnt_b_q, i_q, j_q;
  logic          dropped_q;

  logic signed [COEF_W-1:0] a_coef_q, b_coef_q;
  logic [EXPON_W-1:0]       a_expon_q, b_expon_q;

  logic signed [SUM_W-1:0]  pend_coef_q;
  logic [EXPON_W-1:0]       pend_expon_q;
  logic                     pend_valid_q;

  spa_out_t out_q;
  logic     out_valid_q;

  logic                    a_more, b_more, adv_a, adv_b, produce, done;
  logic signed [SUM_W-1:0] cand_coef, sum_coef;
  logic [EXPON_W-1:0]      cand_expon;
  logic                    out_free, push_step;

  assign out_free  = !out_valid_q || out_ready_i;
  assign push_step = cmd_i.step && produce && pend_valid_q;

  // exact sum of the two sign-extended coefficients
  assign sum_coef = {a_coef_q[COEF_W-1], a_coef_q} + {b_coef_q[COEF_W-1], b_coef_q};

  always_comb begin
    a_more     = i_q < cnt_a_q;
    b_more     = j_q < cnt_b_q;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    produce    = 1'b0;
    done       = 1'b0;
    cand_coef  = '0;
    cand_expon = '0;
    if (a_more && b_more) begin
      if (a_expon_q > b_expon_q) begin
        adv_a      = 1'b1;
        produce    = 1'b1;
        cand_coef  = {a_coef_q[COEF_W-1], a_coef_q};
        cand_expon = a_expon_q;
      end else if (a_expon_q < b_expon_q) begin
        adv_b      = 1'b1;
        produce    = 1'b1;
        cand_coef  = {b_coef_q[COEF_W-1], b_coef_q};
        cand_expon = b_expon_q;
      end else begin
        // equal exponents: a zero sum is dropped
        adv_a      = 1'b1;
        adv_b      = 1'b1;
        produce    = (sum_coef != '0);
        cand_coef  = sum_coef;
        cand_expon = a_expon_q;
      end
    end else if (a_more) begin
      adv_a      = 1'b1;
      produce    = 1'b1;
      cand_coef  = {a_coef_q[COEF_W-1], a_coef_q};
      cand_expon = a_expon_q;
    end else if (b_more) begin
      adv_b      = 1'b1;
      produce    = 1'b1;
      cand_coef  = {b_coef_q[COEF_W-1], b_coef_q};
      cand_expon = b_expon_q;
    end else begin
      done = 1'b1;
    end
  end

  assign stat_o = '{done: done, produce: produce, pend_valid: pend_valid_q,
                    out_free: out_free};

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.append_first && (cnt_a_q < DEPTH)) begin
      first_coefs[cnt_a_q[AW-1:0]]  <= in_data_i.term_coef;
      first_expons[cnt_a_q[AW-1:0]] <= in_data_i.term_expon;
    end
    if (cmd_i.append_second && (cnt_b_q < DEPTH)) begin
      second_coefs[cnt_b_q[AW-1:0]]  <= in_data_i.term_coef;
      second_expons[cnt_b_q[AW-1:0]] <= in_data_i.term_expon;
    end
  end

  // registered memory reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      a_coef_q  <= first_coefs[i_q[AW-1:0]];
      a_expon_q <= first_expons[i_q[AW-1:0]];
      b_coef_q  <= second_coefs[j_q[AW-1:0]];
      b_expon_q <= second_expons[j_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.flush) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      if (cmd_i.append_first) begin
        if (cnt_a_q < DEPTH) cnt_a_q <= cnt_a_q + CW'(1);
        else                 dropped_q <= 1'b1;
      end
      if (cmd_i.append_second) begin
        if (cnt_b_q < DEPTH) cnt_b_q <= cnt_b_q + CW'(1);
        else                 dropped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.merge_start) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.step) begin
      if (adv_a) i_q <= i_q + CW'(1);
      if (adv_b) j_q <= j_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.merge_start || cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.step && produce) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && produce) begin
      pend_coef_q  <= cand_coef;
      pend_expon_q <= cand_expon;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_step || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_step) begin
      out_q <= '{out_coef: pend_coef_q, out_expon: pend_expon_q, term_valid: 1'b1,
                 last_term: 1'b0, overflow: dropped_q};
    end else if (cmd_i.flush) begin
      // empty sum gives one result with no term
      if (pend_valid_q) begin
        out_q <= '{out_coef: pend_coef_q, out_expon: pend_expon_q, term_valid: 1'b1,
                   last_term: 1'b1, overflow: dropped_q};
      end else begin
        out_q <= '{out_coef: '0, out_expon: '0, term_valid: 1'b0,
                   last_term: 1'b1, overflow: dropped_q};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_step || cmd_i.flush) |-> out_free)
    else $error("result register loaded while a result is still waiting");

  a_no_step_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !done)
    else $error("merge stepped past the end of both lists");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= DEPTH) && (cnt_b_q <= DEPTH))
    else $error("list fill count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/sparse_polynomial_add.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_add
// Adds two sparse polynomials held as term lists in falling exponent order.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): cmd appends a term to
// the first or second list, or starts a merge; the unused code is taken and
// ignored. A term appended beyond TERMS_PER_LIST is dropped and sets the
// overflow flag reported with the next merge.
// Output channel (out_valid_o/out_ready_i, out_data_o): one transfer per sum
// term, highest exponent first, last_term set on the final one. An empty sum
// gives a single transfer with term_valid low.
// Each merge step is a registered memory read followed by a compare and add;
// results trail by one term, held back so the last one can be marked. No new
// item is taken until the merge has handed its last result to the output
// register. A stalled receiver holds the merge at the next result.
// Reset empties both lists and clears the overflow flag; the term memories
// need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_add
  import spa_pkg::*;
#(
  parameter int unsigned TERMS_PER_LIST = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire spa_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output spa_out_t     out_data_o
);

  spa_cmd_t  cmd;
  spa_stat_t stat;

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spa_dpath #(
    .TERMS_PER_LIST (TERMS_PER_LIST)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: bench/sparse_polynomial_add_test.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_add_test
// Loads pairs of term lists into the sparse polynomial adder, starts merges
// and checks every sum term against a merge of the same lists kept in the
// bench. Both channels idle at random; one long receiver stall fills the block.
// ----------------------------------------------------------------------------

module sparse_polynomial_add_test
  import spa_pkg::*;
();

  localparam int TERMS_PER_LIST = 32;
  localparam int CLK_HALF       = 5;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 310;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class poly_sum_scoreboard;
    spa_in_t  first_terms[$];
    spa_in_t  second_terms[$];
    bit       dropped;
    spa_out_t sum_terms_due[$];
    int       errors;

    function new();
      dropped = 1'b0;
      errors  = 0;
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    // one accepted transfer on the input side
    function void note_item(spa_in_t item);
      logic signed [32:0] coefs[$];
      logic [15:0]        expons[$];
      logic signed [32:0] s;
      spa_in_t            a;
      spa_in_t            b;
      spa_out_t           t;
      int                 i;
      int                 j;
      int                 k;
      case (item.cmd)
        OP_APPEND_FIRST: begin
          if (first_terms.size() < TERMS_PER_LIST) first_terms.push_back(item);
          else dropped = 1'b1;
        end
        OP_APPEND_SECOND: begin
          if (second_terms.size() < TERMS_PER_LIST) second_terms.push_back(item);
          else dropped = 1'b1;
        end
        OP_MERGE: begin
          i = 0;
          j = 0;
          while (i < first_terms.size() && j < second_terms.size()) begin
            a = first_terms[i];
            b = second_terms[j];
            if (a.term_expon > b.term_expon) begin
              coefs.push_back({a.term_coef[31], a.term_coef});
              expons.push_back(a.term_expon);
              i++;
            end else if (a.term_expon < b.term_expon) begin
              coefs.push_back({b.term_coef[31], b.term_coef});
              expons.push_back(b.term_expon);
              j++;
            end else begin
              s = {a.term_coef[31], a.term_coef} + {b.term_coef[31], b.term_coef};
              if (s != 0) begin
                coefs.push_back(s);
                expons.push_back(a.term_expon);
              end
              i++;
              j++;
            end
          end
          for (; i < first_terms.size(); i++) begin
            a = first_terms[i];
            coefs.push_back({a.term_coef[31], a.term_coef});
            expons.push_back(a.term_expon);
          end
          for (; j < second_terms.size(); j++) begin
            b = second_terms[j];
            coefs.push_back({b.term_coef[31], b.term_coef});
            expons.push_back(b.term_expon);
          end
          if (coefs.size() == 0) begin
            // empty sum still gives one transfer
            t = '0;
            t.last_term = 1'b1;
            t.overflow  = dropped;
            sum_terms_due.push_back(t);
          end
          for (k = 0; k < coefs.size(); k++) begin
            t.out_coef   = coefs[k];
            t.out_expon  = expons[k];
            t.term_valid = 1'b1;
            t.last_term  = (k == coefs.size() - 1);
            t.overflow   = dropped;
            sum_terms_due.push_back(t);
          end
          first_terms.delete();
          second_terms.delete();
          dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task check_term(spa_out_t got);
      spa_out_t want;
      if (sum_terms_due.size() == 0) begin
        report_mismatch("sum term with none due, out_coef", $signed(got.out_coef), 0);
      end else begin
        want = sum_terms_due.pop_front();
        if (got.out_coef !== want.out_coef)
          report_mismatch("out_coef", $signed(got.out_coef), $signed(want.out_coef));
        if (got.out_expon !== want.out_expon)
          report_mismatch("out_expon", got.out_expon, want.out_expon);
        if (got.term_valid !== want.term_valid)
          report_mismatch("term_valid", got.term_valid, want.term_valid);
        if (got.last_term !== want.last_term)
          report_mismatch("last_term", got.last_term, want.last_term);
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", got.overflow, want.overflow);
      end
    endtask
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  spa_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  spa_out_t out_data_o;

  poly_sum_scoreboard board;
  int send_idle_pct     = 20;
  int recv_idle_pct     = 53;
  int ready_hold_cycles = 0;
  int items_sent        = 0;
  int cycle_count       = 0;

  always #CLK_HALF clk_i = ~clk_i;

  sparse_polynomial_add #(
    .TERMS_PER_LIST(TERMS_PER_LIST)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: checks each output transfer, stalls at random or for a set stretch
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) board.check_term(out_data_o);
      if (ready_hold_cycles > 0) begin
        ready_hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic spa_in_t pack_item(logic [1:0] op, logic [31:0] coef,
                                        logic [15:0] expon);
    spa_in_t item;
    item.cmd        = op;
    item.term_coef  = coef;
    item.term_expon = expon;
    return item;
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_item(input spa_in_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(item);
    if (item.cmd != OP_UNUSED) items_sent++;
  endtask

  // builds two lists over one exponent sequence (falling unless scrambled), shares some exponents
  task automatic send_poly_pair(input int union_len, input bit scrambled,
                                input bit noisy);
    spa_in_t     firsts[$];
    spa_in_t     seconds[$];
    logic [31:0] c;
    logic [15:0] e;
    int          cur;
    int          left;
    int          pick;
    int          t;
    if ($urandom_range(4) == 0) cur = 65535;
    else cur = $urandom_range(65535, union_len);
    for (t = 0; t < union_len; t++) begin
      if (scrambled) e = 16'($urandom_range(65535));
      else e = cur[15:0];
      c    = pick_coef();
      pick = $urandom_range(2);
      if (pick != 1) firsts.push_back(pack_item(OP_APPEND_FIRST, c, e));
      if (pick != 0) begin
        if (pick == 2 && $urandom_range(2) == 0) c = -c;
        else c = pick_coef();
        seconds.push_back(pack_item(OP_APPEND_SECOND, c, e));
      end
      left = union_len - 1 - t;
      if (left > 0) cur = cur - 1 - $urandom_range((cur - left) / left);
    end
    while (firsts.size() + seconds.size() > 0) begin
      if (noisy && $urandom_range(19) == 0)
        send_item(pack_item(OP_UNUSED, $urandom(), 16'($urandom())));
      if (noisy && $urandom_range(39) == 0)
        send_item(pack_item(OP_MERGE, $urandom(), 16'($urandom())));
      if (seconds.size() == 0 || (firsts.size() > 0 && $urandom_range(1)))
        send_item(firsts.pop_front());
      else
        send_item(seconds.pop_front());
    end
    send_item(pack_item(OP_MERGE, $urandom(), 16'($urandom())));
  endtask

  initial begin : stimulus
    int base;
    int random_done;
    int mode;
    int len;
    int t;
    bit pressure_done;
    board         = new();
    pressure_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty sum from two empty lists, then an ignored command
    send_item(pack_item(OP_MERGE, '0, '0));
    send_item(pack_item(OP_UNUSED, '1, '1));
    // largest and smallest exact sums at the exponent extremes
    send_item(pack_item(OP_APPEND_FIRST, 32'h7fff_ffff, 16'hffff));
    send_item(pack_item(OP_APPEND_SECOND, 32'h7fff_ffff, 16'hffff));
    send_item(pack_item(OP_APPEND_FIRST, 32'h8000_0000, 16'h0000));
    send_item(pack_item(OP_APPEND_SECOND, 32'h8000_0000, 16'h0000));
    send_item(pack_item(OP_MERGE, '1, '1));
    // cancelling pair dropped, lone zero coefficient kept
    send_item(pack_item(OP_APPEND_FIRST, 32'd5, 16'd100));
    send_item(pack_item(OP_APPEND_FIRST, 32'd0, 16'd50));
    send_item(pack_item(OP_UNUSED, 32'd77, 16'd77));
    send_item(pack_item(OP_APPEND_SECOND, -32'sd5, 16'd100));
    send_item(pack_item(OP_APPEND_SECOND, 32'd1, 16'd40));
    send_item(pack_item(OP_MERGE, '0, '0));
    // everything cancels
    send_item(pack_item(OP_APPEND_FIRST, 32'd9, 16'd3));
    send_item(pack_item(OP_APPEND_SECOND, -32'sd9, 16'd3));
    send_item(pack_item(OP_MERGE, '0, '0));
    // lists out of order
    send_item(pack_item(OP_APPEND_FIRST, 32'd1, 16'd10));
    send_item(pack_item(OP_APPEND_FIRST, 32'd2, 16'd20));
    send_item(pack_item(OP_APPEND_SECOND, 32'd3, 16'd15));
    send_item(pack_item(OP_APPEND_SECOND, 32'd4, 16'd5));
    send_item(pack_item(OP_MERGE, '0, '0));
    // second list only
    send_item(pack_item(OP_APPEND_SECOND, 32'hdead_beef, 16'h8000));
    send_item(pack_item(OP_APPEND_SECOND, 32'h1234_5678, 16'h7fff));
    send_item(pack_item(OP_MERGE, '0, '0));

    base = items_sent;
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (random_done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 53;
      end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (!pressure_done) begin
          // receiver stalls while both lists overfill and a merge backs up
          pressure_done = 1'b1;
          ready_hold_cycles = HOLD_CYCLES;
          for (t = 0; t < TERMS_PER_LIST + 2; t++) begin
            send_item(pack_item(OP_APPEND_FIRST, pick_coef(), 16'(40000 - 1000 * t)));
            send_item(pack_item(OP_APPEND_SECOND, pick_coef(),
                                16'(40000 - 1000 * t - 500 * (t % 2))));
          end
          send_item(pack_item(OP_MERGE, $urandom(), 16'($urandom())));
          send_poly_pair(6, 1'b0, 1'b0);
        end
      end
      mode = $urandom_range(19);
      if (mode < 14) len = $urandom_range(8);
      else if (mode < 17) len = $urandom_range(24, 9);
      else len = $urandom_range(48, 28);
      send_poly_pair(len, ($urandom_range(9) == 0), ($urandom_range(2) == 0));
      random_done = items_sent - base;
    end
    in_valid_i <= 1'b0;

    while (board.sum_terms_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/spa_pkg.sv
rtl/spa_ctrl.sv
rtl/spa_dpath.sv
rtl/sparse_polynomial_add.sv
bench/sparse_polynomial_add_test.sv
